### hw/rtl/unsigned_to_ascii_digits_assert.svh
// Assertion macros for the integer-to-ASCII digit converter.
// Depends on a clock named clock and an active-high reset named reset in scope.
`ifndef UNSIGNED_TO_ASCII_DIGITS_ASSERT_SVH
`define UNSIGNED_TO_ASCII_DIGITS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define U2A_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define U2A_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/u2a_pkg.sv
// Shared types, constants and functions for the integer-to-ASCII converter.
// No dependencies.
`default_nettype none

package u2a_pkg;

   // Significant bits of the input value; also the deepest digit count (binary).
   localparam int VALUE_WIDTH = 32;
   localparam int DIGIT_DEPTH = VALUE_WIDTH;
   localparam int COUNT_W     = $clog2(DIGIT_DEPTH + 1);
   localparam int DIGIT_W     = 4;

   // Reciprocal of ten: ceil(2^(W+3) / 10), exact quotient for any W-bit dividend.
   localparam int RECIP_SHIFT = VALUE_WIDTH + 3;
   localparam logic [VALUE_WIDTH+4:0] RECIP_POW = {2'b01, {RECIP_SHIFT{1'b0}}};
   localparam logic [VALUE_WIDTH+4:0] RECIP_FULL =
      (RECIP_POW + (VALUE_WIDTH + 5)'(9)) / (VALUE_WIDTH + 5)'(10);
   localparam logic [VALUE_WIDTH-1:0] RECIP_TEN = RECIP_FULL[VALUE_WIDTH-1:0];

   localparam logic [6:0] ASCII_ZERO  = 7'h30;
   localparam logic [6:0] ASCII_UPPER = 7'h41;
   localparam logic [6:0] ASCII_LOWER = 7'h61;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

   typedef enum logic [1:0] {
      BASE_BIN = 2'd0,
      BASE_OCT = 2'd1,
      BASE_DEC = 2'd2,
      BASE_HEX = 2'd3
   } base_type;

   // Result of one pass through the radix divider.
   typedef struct packed {
      logic                   done;
      logic [VALUE_WIDTH-1:0] quot;
      logic [DIGIT_W-1:0]     rem;
   } div_res_type;

   // Digit stack control.
   typedef struct packed {
      logic               push;
      logic               pop;
      logic [DIGIT_W-1:0] digit;
   } stack_ctl_type;

   function automatic logic [6:0] digit_ascii(input logic [DIGIT_W-1:0] d,
                                              input logic upper);
      logic [6:0] d7;
      d7 = {3'b000, d};
      if (d < DIGIT_TEN) begin
         return ASCII_ZERO + d7;
      end
      return (upper ? ASCII_UPPER : ASCII_LOWER) + d7 - {3'b000, DIGIT_TEN};
   endfunction

endpackage

`default_nettype wire

### hw/rtl/unsigned_to_ascii_digits.sv
// Top level of the integer-to-ASCII converter: sequencer, divider and digit stack.
// Depends on u2a_pkg, u2a_div, u2a_stack and unsigned_to_ascii_digits_assert.svh.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_ready  value, base_select, upper_hex
//   rsp_     out        rsp_valid / rsp_ready  digit_char, last_digit
//
// An item producing n digits takes one divider pass per digit in the shared divider
// (reciprocal product registered, quotient and remainder settle the next cycle),
// then one pop per digit from the stack, n from 1 to 32 (binary of a 32-bit value).
// Reset is synchronous and active high; it clears the sequencer and output valid.
// A stalled rsp_ready holds the output register and pauses the digit stack.
// The next transaction is taken as soon as the last digit sits in the output register.
`default_nettype none

`include "unsigned_to_ascii_digits_assert.svh"

module unsigned_to_ascii_digits (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_value,
   input  wire logic [1:0]  req_base_select,
   input  wire logic        req_upper_hex,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [6:0]       rsp_digit_char,
   output logic             rsp_last_digit
);

   localparam int W = u2a_pkg::VALUE_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type                  state_ff, state_in;
   logic [u2a_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                       upper_ff;
   u2a_pkg::base_type          base_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [6:0]                 rsp_char_ff;
   logic                       rsp_last_ff;

   logic                        accept;
   logic                        div_load;
   logic [W-1:0]                div_dvd;
   u2a_pkg::base_type           div_base;
   u2a_pkg::div_res_type        div_res;
   u2a_pkg::stack_ctl_type      stk_ctl;
   logic [u2a_pkg::DIGIT_W-1:0] stk_top;
   logic                        out_free;
   logic                        emit;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = (state_ff == ST_EMIT) && out_free;

   // Feed the divider: the fresh value on accept, else the last quotient.
   always_comb begin
      div_load = accept ||
                 ((state_ff == ST_DIV) && div_res.done && (div_res.quot != '0));
      div_dvd  = accept ? req_value[W-1:0] : div_res.quot;
      div_base = accept ? u2a_pkg::base_type'(req_base_select) : base_ff;
   end

   u2a_div u_div (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .dividend (div_dvd),
      .base     (div_base),
      .res      (div_res)
   );

   // Push each remainder as it comes out; pop while emitting.
   always_comb begin
      stk_ctl.push  = (state_ff == ST_DIV) && div_res.done;
      stk_ctl.pop   = emit;
      stk_ctl.digit = div_res.rem;
   end

   u2a_stack u_stack (
      .clock (clock),
      .ctl   (stk_ctl),
      .top   (stk_top)
   );

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            count_in = '0;
            if (accept) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               count_in = count_ff + 1'b1;
               if (div_res.quot == '0) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               count_in     = count_ff - 1'b1;
               if (count_ff == u2a_pkg::COUNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         upper_ff <= req_upper_hex;
         base_ff  <= u2a_pkg::base_type'(req_base_select);
      end
      if (emit) begin
         rsp_char_ff <= u2a_pkg::digit_ascii(stk_top, upper_ff);
         rsp_last_ff <= (count_ff == u2a_pkg::COUNT_W'(1));
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last_digit = rsp_last_ff;

   // Checks.
   `U2A_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= u2a_pkg::COUNT_W'(u2a_pkg::DIGIT_DEPTH),
      "digit count beyond stack depth")
   `U2A_ASSERT_NOW(a_emit_nonempty, state_ff == ST_EMIT, count_ff != '0,
      "emitting from an empty digit stack")
   `U2A_ASSERT_NEXT(a_last_idle, emit && (count_ff == u2a_pkg::COUNT_W'(1)),
      state_ff == ST_IDLE, "sequencer not idle after the last digit")
   `U2A_ASSERT_NOW(a_div_in_div, div_res.done, state_ff == ST_DIV,
      "divider result outside divide phase")

endmodule

`default_nettype wire

### hw/rtl/u2a_div.sv
// Shared radix divider: quotient and remainder by 2, 8, 10 or 16, ready the cycle after load.
// Depends on u2a_pkg.
`default_nettype none

module u2a_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            load,
   input  wire logic [u2a_pkg::VALUE_WIDTH-1:0] dividend,
   input  wire u2a_pkg::base_type               base,
   output u2a_pkg::div_res_type                 res
);

   localparam int W = u2a_pkg::VALUE_WIDTH;

   logic [W-1:0]           dvd_ff;
   u2a_pkg::base_type      base_ff;
   logic [2*W-1:0]         prod_ff, prod_in;
   logic                   done_ff;
   logic [W-1:0]           q10;
   logic [u2a_pkg::DIGIT_W-1:0] q10_x10, r10;

   assign prod_in = {{W{1'b0}}, dividend} * {{W{1'b0}}, u2a_pkg::RECIP_TEN};

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= load;
      end
      if (load) begin
         dvd_ff  <= dividend;
         base_ff <= base;
         prod_ff <= prod_in;
      end
   end

   // Remainder by ten is below ten, so the low nibble settles it.
   always_comb begin
      q10     = W'(prod_ff[2*W-1:u2a_pkg::RECIP_SHIFT]);
      q10_x10 = {q10[0], 3'b000} + {q10[2:0], 1'b0};
      r10     = dvd_ff[3:0] - q10_x10;
   end

   always_comb begin
      res.done = done_ff;
      case (base_ff)
         u2a_pkg::BASE_BIN: begin
            res.quot = dvd_ff >> 1;
            res.rem  = {3'b000, dvd_ff[0]};
         end
         u2a_pkg::BASE_OCT: begin
            res.quot = dvd_ff >> 3;
            res.rem  = {1'b0, dvd_ff[2:0]};
         end
         u2a_pkg::BASE_DEC: begin
            res.quot = q10;
            res.rem  = r10;
         end
         default: begin
            res.quot = dvd_ff >> 4;
            res.rem  = dvd_ff[3:0];
         end
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/u2a_stack.sv
// Last-in first-out digit stack: digits come out most significant first.
// Depends on u2a_pkg.
`default_nettype none

module u2a_stack (
   input  wire logic                            clock,
   input  wire u2a_pkg::stack_ctl_type          ctl,
   output logic [u2a_pkg::DIGIT_W-1:0]          top
);

   localparam int DEPTH = u2a_pkg::DIGIT_DEPTH;

   logic [u2a_pkg::DIGIT_W-1:0] entry_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         entry_ff[0] <= ctl.digit;
         for (int i = 1; i < DEPTH; i++) begin
            entry_ff[i] <= entry_ff[i-1];
         end
      end else if (ctl.pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            entry_ff[i] <= entry_ff[i+1];
         end
         entry_ff[DEPTH-1] <= '0;
      end
   end

   assign top = entry_ff[0];

endmodule

`default_nettype wire

### dv/tb_unsigned_to_ascii_digits.sv
// Self-checking testbench for unsigned_to_ascii_digits: drives numbers in every radix and
// checks each ASCII digit and last-digit flag against a digit predictor kept in the bench.
// Depends on u2a_pkg (base_type) and the unsigned_to_ascii_digits RTL.
`timescale 1ns / 100ps

module tb_unsigned_to_ascii_digits;

   // Room for the slowest correct run: 130 numbers, each up to 32 digits, each digit held
   // by the longest ready stall, plus request gaps and the per-digit work inside the block.
   localparam int CYCLE_LIMIT  = 500_000;
   localparam int DRAIN_CYCLES = 120;
   localparam int CALM_ITEMS   = 25;
   localparam int RANDOM_ITEMS = 106;

   typedef struct {
      logic [31:0]       value;
      u2a_pkg::base_type base;
      logic              upper;
   } number_type;

   typedef struct {
      logic [6:0] ch;
      logic       last;
   } digit_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_value = '0;
   logic [1:0]  req_base_select = '0;
   logic        req_upper_hex = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [6:0]  rsp_digit_char;
   logic        rsp_last_digit;

   number_type pending_numbers[$];
   digit_type  expected_digits[$];
   number_type next_number;
   digit_type  want;

   bit req_took;
   bit failed;
   int num_issued;
   int calm_from = 32'h7fff_ffff;
   int req_gap;
   int rsp_gap;
   int cycle_count;

   wire calm_phase = (num_issued >= calm_from);

   unsigned_to_ascii_digits dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value       (req_value),
      .req_base_select (req_base_select),
      .req_upper_hex   (req_upper_hex),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digit_char  (rsp_digit_char),
      .rsp_last_digit  (rsp_last_digit)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Expand one number into its digit string, most significant first, and queue each
   // character with its last-digit flag. Zero still yields one '0'.
   function automatic void predict_digits(input logic [31:0] value,
                                          input u2a_pkg::base_type base,
                                          input logic upper);
      logic [6:0]  chars[$];
      logic [31:0] rest;
      int unsigned radix;
      int unsigned d;
      digit_type   e;
      int          k;
      rest = value;
      case (base)
         u2a_pkg::BASE_BIN: radix = 2;
         u2a_pkg::BASE_OCT: radix = 8;
         u2a_pkg::BASE_DEC: radix = 10;
         default:           radix = 16;
      endcase
      do begin
         d    = rest % radix;
         rest = rest / radix;
         // Letter case only matters for hex digits above nine.
         if (d < 10) chars.push_front(7'("0" + d));
         else        chars.push_front(7'((upper ? "A" : "a") + d - 10));
      end while (rest != 0);
      for (k = 0; k < chars.size(); k++) begin
         e.ch   = chars[k];
         e.last = (k == chars.size() - 1);
         expected_digits.push_back(e);
      end
   endfunction

   task automatic add_number(input logic [31:0] value, input u2a_pkg::base_type base,
                             input logic upper);
      number_type n;
      n.value = value;
      n.base  = base;
      n.upper = upper;
      pending_numbers.push_back(n);
   endtask

   // Request driver: advance on the falling edge. Hold valid and payload until the
   // transaction is taken; outside the calm tail, sometimes add an idle burst first.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else if (!req_valid || req_took) begin
         if (req_gap != 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_numbers.size() != 0 &&
                      (calm_phase || $urandom_range(0, 5) != 0)) begin
            next_number     = pending_numbers.pop_front();
            req_valid       <= 1'b1;
            req_value       <= next_number.value;
            req_base_select <= next_number.base;
            req_upper_hex   <= next_number.upper;
            num_issued      <= num_issued + 1;
         end else begin
            // This cycle is the first of the burst; queue up the rest of it.
            req_valid <= 1'b0;
            if (!calm_phase && pending_numbers.size() != 0) req_gap <= $urandom_range(0, 13);
         end
      end
   end

   // Response backpressure: drop ready for random bursts, none begun in the calm tail.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= 0;
      end else if (rsp_gap != 0) begin
         rsp_gap   <= rsp_gap - 1;
         rsp_ready <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
         rsp_gap   <= $urandom_range(0, 13);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: sample both channels on the rising edge. Check the digit first so that a
   // number taken in the same cycle can never satisfy an output that came before it.
   always @(posedge clock) begin
      req_took <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_digits.size() == 0) begin
               $error("unexpected digit: digit_char %h last_digit %b",
                      rsp_digit_char, rsp_last_digit);
               failed = 1'b1;
            end else begin
               want = expected_digits.pop_front();
               if (rsp_digit_char !== want.ch) begin
                  $error("digit_char mismatch: expected %h, actual %h", want.ch,
                         rsp_digit_char);
                  failed = 1'b1;
               end
               if (rsp_last_digit !== want.last) begin
                  $error("last_digit mismatch: expected %b, actual %b", want.last,
                         rsp_last_digit);
                  failed = 1'b1;
               end
            end
         end
         if (req_valid && req_ready)
            predict_digits(req_value, u2a_pkg::base_type'(req_base_select), req_upper_hex);
      end
   end

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin : stimulus
      logic [31:0] v;
      int          i;

      // Directed: zero and one-digit values per radix, values equal to the radix, the
      // full-scale value in every radix, and both letter cases (ignored outside hex).
      add_number(32'd0, u2a_pkg::BASE_BIN, 1'b0);
      add_number(32'd0, u2a_pkg::BASE_OCT, 1'b1);
      add_number(32'd0, u2a_pkg::BASE_DEC, 1'b0);
      add_number(32'd0, u2a_pkg::BASE_HEX, 1'b1);
      add_number(32'd1, u2a_pkg::BASE_BIN, 1'b0);
      add_number(32'd7, u2a_pkg::BASE_OCT, 1'b0);
      add_number(32'd9, u2a_pkg::BASE_DEC, 1'b1);
      add_number(32'd15, u2a_pkg::BASE_HEX, 1'b1);
      add_number(32'd15, u2a_pkg::BASE_HEX, 1'b0);
      add_number(32'd2, u2a_pkg::BASE_BIN, 1'b0);
      add_number(32'd8, u2a_pkg::BASE_OCT, 1'b1);
      add_number(32'd10, u2a_pkg::BASE_DEC, 1'b0);
      add_number(32'd16, u2a_pkg::BASE_HEX, 1'b0);
      add_number(32'hffff_ffff, u2a_pkg::BASE_BIN, 1'b1);
      add_number(32'hffff_ffff, u2a_pkg::BASE_OCT, 1'b0);
      add_number(32'hffff_ffff, u2a_pkg::BASE_DEC, 1'b0);
      add_number(32'hffff_ffff, u2a_pkg::BASE_HEX, 1'b1);
      add_number(32'hffff_ffff, u2a_pkg::BASE_HEX, 1'b0);
      add_number(32'h8000_0000, u2a_pkg::BASE_BIN, 1'b0);
      add_number(32'hdead_beef, u2a_pkg::BASE_HEX, 1'b0);
      add_number(32'h0abc_def9, u2a_pkg::BASE_HEX, 1'b1);
      add_number(32'd999_999_999, u2a_pkg::BASE_DEC, 1'b0);
      add_number(32'd1_000_000_000, u2a_pkg::BASE_DEC, 1'b1);
      add_number(32'h1234_5678, u2a_pkg::BASE_OCT, 1'b1);

      // Random: full-range values, tiny values, values of random length, and values
      // straddling a power of two where the digit count changes.
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         case ($urandom_range(0, 3))
            0:       v = $urandom;
            1:       v = $urandom_range(0, 20);
            2:       v = $urandom >> $urandom_range(1, 31);
            default: v = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
         endcase
         add_number(v, u2a_pkg::base_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
      calm_from = pending_numbers.size() - CALM_ITEMS;

      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Wait until every number is taken and every digit has come back.
      do @(posedge clock);
      while (pending_numbers.size() != 0 || req_valid || expected_digits.size() != 0);

      // Let any stray digit show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/u2a_pkg.sv
hw/rtl/u2a_div.sv
hw/rtl/u2a_stack.sv
hw/rtl/unsigned_to_ascii_digits.sv
dv/tb_unsigned_to_ascii_digits.sv
